/* src/pis_pkg.sv */
// ----------------------------------------------------------------------------
// Pulse inject sequencer package
// Shared types and constants for the sequencer, its register file and its core.
// ----------------------------------------------------------------------------
package pis_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned IdxW   = 2;

  // Register indexes on the configuration channel.
  localparam logic [IdxW-1:0] REG_ENABLE  = 2'd0;
  localparam logic [IdxW-1:0] REG_HOLDOFF = 2'd1;
  localparam logic [IdxW-1:0] REG_HIGH    = 2'd2;
  localparam logic [IdxW-1:0] REG_LOW     = 2'd3;

  // Register reset values.
  localparam logic [MsW-1:0] HOLDOFF_RST = 16'd120;
  localparam logic [MsW-1:0] HIGH_RST    = 16'd8;
  localparam logic [MsW-1:0] LOW_RST     = 16'd8;

  // Codes reported on the fsm_state output.
  localparam logic [1:0] STATE_IDLE = 2'd0;
  localparam logic [1:0] STATE_HIGH = 2'd1;
  localparam logic [1:0] STATE_LOW  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  typedef struct packed {
    logic             enable;
    logic [MsW-1:0]   holdoff_ms;
    logic [MsW-1:0]   high_ms;
    logic [MsW-1:0]   low_ms;
    logic             enable_wr;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             watch_level;
    logic             attach_level;
    logic             drive_ok;
    logic             clear_stats;
  } item_t;

  typedef struct packed {
    logic              drive_active;
    logic              drive_level;
    logic [1:0]        fsm_state;
    logic [CountW-1:0] trigger_total;
    logic [CountW-1:0] success_total;
    logic [CountW-1:0] timeout_total;
    logic [CountW-1:0] active_ticks;
  } res_t;

endpackage

/* src/pis_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Pulse inject sequencer register file
// Holds the four configuration registers and flags writes to the enable.
// ----------------------------------------------------------------------------
module pis_cfg_regs
  import pis_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [IdxW-1:0]           wr_index,
  input  logic [MsW-1:0]            wr_data,
  output cfg_t                      cfg
);

  logic           enable;
  logic [MsW-1:0] holdoff_ms;
  logic [MsW-1:0] high_ms;
  logic [MsW-1:0] low_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      holdoff_ms <= HOLDOFF_RST;
      high_ms    <= HIGH_RST;
      low_ms     <= LOW_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENABLE:  enable     <= wr_data[0];
        REG_HOLDOFF: holdoff_ms <= wr_data;
        REG_HIGH:    high_ms    <= wr_data;
        REG_LOW:     low_ms     <= wr_data;
        default:     enable     <= enable;
      endcase
    end
  end

  // The enable write strobe acts in the same cycle as the write itself.
  assign cfg.enable     = enable;
  assign cfg.holdoff_ms = holdoff_ms;
  assign cfg.high_ms    = high_ms;
  assign cfg.low_ms     = low_ms;
  assign cfg.enable_wr  = wr_en && (wr_index == REG_ENABLE);

endmodule

/* src/pis_core.sv */
// ----------------------------------------------------------------------------
// Pulse inject sequencer core
// Sequencer state, counters and the one-tick update computed on each item.
// ----------------------------------------------------------------------------
module pis_core
  import pis_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res_next
);

  phase_t            phase, phase_next;
  logic [TimeW-1:0]  deadline, deadline_next;
  logic [TimeW-1:0]  last_trigger, last_trigger_next;
  logic              prev_watch, prev_watch_next;
  logic              prev_attach, prev_attach_next;
  logic              saw_change, saw_change_next;
  logic [CountW-1:0] count_triggers, count_triggers_next;
  logic [CountW-1:0] count_success, count_success_next;
  logic [CountW-1:0] count_timeout, count_timeout_next;
  logic [CountW-1:0] count_active, count_active_next;
  logic [TimeW-1:0]  since_trigger;
  logic [TimeW-1:0]  to_deadline;
  logic              reached;
  logic              holdoff_done;

  assign since_trigger = item.now_ms - last_trigger;
  assign to_deadline   = item.now_ms - deadline;
  assign reached       = !to_deadline[TimeW-1];
  assign holdoff_done  = since_trigger >= {{(TimeW-MsW){1'b0}}, cfg.holdoff_ms};

  always_comb begin
    phase_next          = phase;
    deadline_next       = deadline;
    last_trigger_next   = last_trigger;
    saw_change_next     = saw_change;
    count_triggers_next = count_triggers;
    count_success_next  = count_success;
    count_timeout_next  = count_timeout;
    count_active_next   = count_active;
    prev_watch_next     = item.watch_level;
    prev_attach_next    = item.attach_level;

    if (item.clear_stats) begin
      count_triggers_next = '0;
      count_success_next  = '0;
      count_timeout_next  = '0;
      count_active_next   = '0;
    end

    if (cfg.enable) begin
      count_active_next = count_active_next + 1'b1;
      if ((item.watch_level != prev_watch) || (item.attach_level != prev_attach)) begin
        saw_change_next = 1'b1;
      end
      case (phase)
        PH_IDLE: begin
          if (!item.attach_level && holdoff_done && item.drive_ok) begin
            count_triggers_next = count_triggers_next + 1'b1;
            phase_next          = PH_HIGH;
            deadline_next       = item.now_ms + {{(TimeW-MsW){1'b0}}, cfg.high_ms};
            last_trigger_next   = item.now_ms;
            saw_change_next     = 1'b0;
          end
        end
        PH_HIGH: begin
          if (reached) begin
            if (item.drive_ok) begin
              phase_next    = PH_LOW;
              deadline_next = item.now_ms + {{(TimeW-MsW){1'b0}}, cfg.low_ms};
            end else begin
              phase_next          = PH_IDLE;
              deadline_next       = '0;
              saw_change_next     = 1'b0;
              count_timeout_next  = count_timeout_next + 1'b1;
            end
          end
        end
        PH_LOW: begin
          if (reached) begin
            if (saw_change_next) begin
              count_success_next = count_success_next + 1'b1;
            end else begin
              count_timeout_next = count_timeout_next + 1'b1;
            end
            phase_next      = PH_IDLE;
            deadline_next   = '0;
            saw_change_next = 1'b0;
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          deadline_next   = '0;
          saw_change_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      deadline       <= '0;
      last_trigger   <= '0;
      prev_watch     <= 1'b0;
      prev_attach    <= 1'b0;
      saw_change     <= 1'b0;
      count_triggers <= '0;
      count_success  <= '0;
      count_timeout  <= '0;
      count_active   <= '0;
    end else if (cfg.enable_wr) begin
      phase        <= PH_IDLE;
      deadline     <= '0;
      saw_change   <= 1'b0;
      last_trigger <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      deadline       <= deadline_next;
      last_trigger   <= last_trigger_next;
      prev_watch     <= prev_watch_next;
      prev_attach    <= prev_attach_next;
      saw_change     <= saw_change_next;
      count_triggers <= count_triggers_next;
      count_success  <= count_success_next;
      count_timeout  <= count_timeout_next;
      count_active   <= count_active_next;
    end
  end

  always_comb begin
    res_next.drive_active = (phase_next != PH_IDLE);
    res_next.drive_level  = (phase_next == PH_HIGH);
    case (phase_next)
      PH_HIGH: res_next.fsm_state = STATE_HIGH;
      PH_LOW:  res_next.fsm_state = STATE_LOW;
      default: res_next.fsm_state = STATE_IDLE;
    endcase
    res_next.trigger_total = count_triggers_next;
    res_next.success_total = count_success_next;
    res_next.timeout_total = count_timeout_next;
    res_next.active_ticks  = count_active_next;
  end

  // An enable write always leaves the sequencer idle with its deadline cleared and no change seen.
  a_enable_wr_idle: assert property (@(posedge clk) disable iff (rst)
    cfg.enable_wr |=> (phase == PH_IDLE) && (deadline == '0) && !saw_change)
    else $error("sequencer not idle after enable write");

  // With no item and no enable write, nothing in the sequencer moves.
  a_hold_without_item: assert property (@(posedge clk) disable iff (rst)
    (!fire && !cfg.enable_wr) |=> $stable(phase) && $stable(count_active)
                                  && $stable(count_triggers))
    else $error("sequencer state changed without an item");

  // A disabled tick never moves the phase.
  a_disabled_phase: assert property (@(posedge clk) disable iff (rst)
    (fire && !cfg.enable && !cfg.enable_wr) |=> $stable(phase))
    else $error("phase changed on a disabled tick");

  // Each enabled tick without a clear adds exactly one to the active count.
  a_active_count: assert property (@(posedge clk) disable iff (rst)
    (fire && cfg.enable && !cfg.enable_wr && !item.clear_stats)
      |=> count_active == $past(count_active) + 1'b1)
    else $error("active tick count did not advance by one");

endmodule

/* src/pulse_inject_sequencer.sv */
// ----------------------------------------------------------------------------
// Pulse inject sequencer
// Timed pulse injector driven by millisecond ticks, with trigger statistics.
// ----------------------------------------------------------------------------
// An item is registered in the input register on acceptance; once it fires, its
// result is loaded into the output register and out_valid rises with it.
// Throughput: one item per cycle while out_ready holds; the state update is a
// single pass of compares and 32-bit increments between input and result registers.
// Reset: synchronous, active high; the sequencer is idle, counters are zero and
// the registers hold enable 0, holdoff 120 ms, high 8 ms and low 8 ms.
module pulse_inject_sequencer
  import pis_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Tick items.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TimeW-1:0]  now_ms,
  input  logic              watch_level,
  input  logic              attach_level,
  input  logic              drive_ok,
  input  logic              clear_stats,
  // Result items.
  output logic              out_valid,
  input  logic              out_ready,
  output logic              drive_active,
  output logic              drive_level,
  output logic [1:0]        fsm_state,
  output logic [CountW-1:0] trigger_total,
  output logic [CountW-1:0] success_total,
  output logic [CountW-1:0] timeout_total,
  output logic [CountW-1:0] active_ticks,
  // Configuration writes.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [MsW-1:0]    cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  res_t  res_next;
  res_t  res;
  logic  fire;

  // Register writes are always taken; the user must write only while the block is idle, as it does not check.
  assign cfg_ready = 1'b1;

  pis_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item is processed when the result register is empty or is being
  // drained in this same cycle. The input register then frees up, so a new
  // item can be taken in every cycle while results keep flowing.
  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.now_ms       <= now_ms;
      item.watch_level  <= watch_level;
      item.attach_level <= attach_level;
      item.drive_ok     <= drive_ok;
      item.clear_stats  <= clear_stats;
    end
  end

  // The core updates its state on fire and presents the post-update view,
  // which is what the result item reports.
  pis_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign drive_active  = res.drive_active;
  assign drive_level   = res.drive_level;
  assign fsm_state     = res.fsm_state;
  assign trigger_total = res.trigger_total;
  assign success_total = res.success_total;
  assign timeout_total = res.timeout_total;
  assign active_ticks  = res.active_ticks;

endmodule
